// ----- rtl/cffa_pkg.sv -----
// Shared types and constants for the contiguous first-fit block allocator.
package cffa_pkg;

  localparam int NUM_BLOCKS_DEF = 32;
  localparam int Q_DEPTH        = 2;

  localparam int KIND_W   = 1;
  localparam int BIDX_W   = 5;
  localparam int FID_W    = 8;
  localparam int FBYTES_W = 16;
  localparam int BSIZE_W  = 13;
  localparam int STATUS_W = 2;
  localparam int START_W  = 5;
  localparam int NEED_W   = 16;
  localparam int PART_W   = 6;

  typedef enum logic [1:0] {
    CLS_FREE  = 2'd0,
    CLS_ZERO  = 2'd1,
    CLS_ALLOC = 2'd2
  } cls_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FREED  = 2'd0,
    ST_ALLOC  = 2'd1,
    ST_NOROOM = 2'd2,
    ST_ZERO   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SCAN,
    BK_MARK
  } bk_state_t;

  typedef struct packed {
    cls_t                cls;
    logic [BIDX_W-1:0]   block_index;
    logic [FID_W-1:0]    file_id;
    logic [FBYTES_W-1:0] file_bytes;
  } req_t;

endpackage

// ----- rtl/cffa_front.sv -----
// Front end: accepts requests, classifies them and holds them in a short queue.
module cffa_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [cffa_pkg::KIND_W-1:0]   kind,
  input  logic [cffa_pkg::BIDX_W-1:0]   block_index,
  input  logic [cffa_pkg::FID_W-1:0]    file_id,
  input  logic [cffa_pkg::FBYTES_W-1:0] file_bytes,
  output logic                          q_valid,
  output cffa_pkg::req_t                q_req,
  input  logic                          pop
);
  import cffa_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  req_t             slots [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  req_t             in_req;

  always_comb begin
    in_req.block_index = block_index;
    in_req.file_id     = file_id;
    in_req.file_bytes  = file_bytes;
    if (kind == KIND_W'(0)) begin
      in_req.cls = CLS_FREE;
    end else if (file_bytes == '0) begin
      in_req.cls = CLS_ZERO;
    end else begin
      in_req.cls = CLS_ALLOC;
    end
  end

  assign busy    = (count == CNT_W'(Q_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (count != '0);
  assign q_req   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop && q_valid) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !(pop && q_valid)) begin
        count <= count + CNT_W'(1);
      end else if (!push && pop && q_valid) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_req;
    end
  end

endmodule

// ----- rtl/cffa_div.sv -----
// Serial restoring divider, one quotient bit per cycle.
module cffa_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [cffa_pkg::NEED_W-1:0]   dividend,
  input  logic [cffa_pkg::BSIZE_W-1:0]  divisor,
  output logic                          done,
  output logic [cffa_pkg::NEED_W-1:0]   quotient
);
  import cffa_pkg::*;

  localparam int CNT_W = $clog2(NEED_W + 1);

  logic [NEED_W-1:0]  dvd;
  logic [BSIZE_W-1:0] dsr;
  logic [BSIZE_W-1:0] rem;
  logic [CNT_W-1:0]   cnt;
  logic               active;
  logic [BSIZE_W:0]   rem_sh;
  logic               q_bit;

  // Shift the next dividend bit into the partial remainder and try to subtract.
  assign rem_sh   = {rem, dvd[NEED_W-1]};
  assign q_bit    = (rem_sh >= {1'b0, dsr});
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        cnt    <= CNT_W'(NEED_W);
      end else if (active) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (active) begin
      dvd <= {dvd[NEED_W-2:0], q_bit};
      rem <= q_bit ? BSIZE_W'(rem_sh - {1'b0, dsr}) : rem_sh[BSIZE_W-1:0];
    end
  end

endmodule

// ----- rtl/cffa_back.sv -----
// Back end: frees, block count, first-fit scan of the free map and marking of the run.
module cffa_back #(
  parameter int NUM_BLOCKS = cffa_pkg::NUM_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  cffa_pkg::req_t                q_req,
  output logic                          pop,
  input  logic [cffa_pkg::BSIZE_W-1:0]  block_bytes,
  output logic                          done,
  output logic [cffa_pkg::STATUS_W-1:0] status,
  output logic [cffa_pkg::START_W-1:0]  start_block,
  output logic [cffa_pkg::NEED_W-1:0]   blocks_needed
);
  import cffa_pkg::*;

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int RUN_W = $clog2(NUM_BLOCKS + 1);

  bk_state_t          state;
  bk_state_t          state_next;
  logic               div_go;
  logic               div_done;
  logic [NEED_W-1:0]  div_q;
  logic [BSIZE_W-1:0] divisor;

  logic [NUM_BLOCKS-1:0] free_map;
  logic [FID_W-1:0]      owner_mem [NUM_BLOCKS];
  logic [PART_W-1:0]     part_mem  [NUM_BLOCKS];

  logic [NEED_W-1:0] need;
  logic [FID_W-1:0]  fid;
  logic [IDX_W-1:0]  scan_idx;
  logic [RUN_W-1:0]  run;
  logic [IDX_W-1:0]  run_start;
  logic [IDX_W-1:0]  mark_k;

  logic              cur_free;
  logic [RUN_W-1:0]  run_inc;
  logic              hit;
  logic              scan_last;
  logic              mark_last;
  logic [IDX_W-1:0]  mark_addr;
  logic [31:0]       bidx_wide;
  logic              free_ok;
  logic [IDX_W-1:0]  free_idx;
  logic [31:0]       part_wide;
  logic [31:0]       start_wide;

  assign divisor    = (block_bytes == '0) ? BSIZE_W'(1) : block_bytes;
  assign cur_free   = free_map[scan_idx];
  assign run_inc    = cur_free ? run + RUN_W'(1) : '0;
  assign hit        = (NEED_W'(run_inc) == need);
  assign scan_last  = (scan_idx == IDX_W'(NUM_BLOCKS - 1));
  assign mark_last  = (NEED_W'(mark_k) == need - NEED_W'(1));
  assign mark_addr  = run_start + mark_k;
  assign bidx_wide  = 32'(q_req.block_index);
  assign free_ok    = (bidx_wide < NUM_BLOCKS);
  assign free_idx   = bidx_wide[IDX_W-1:0];
  assign part_wide  = 32'(mark_k) + 32'd1;
  assign start_wide = 32'(run_start);

  // Ceiling division: a nonzero size s gives (s - 1) / d + 1 blocks.
  cffa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (q_req.file_bytes - NEED_W'(1)),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    div_go     = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (q_req.cls == CLS_ALLOC) begin
            div_go     = 1'b1;
            state_next = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        if (div_done) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (hit) begin
          state_next = BK_MARK;
        end else if (scan_last) begin
          state_next = BK_IDLE;
        end
      end
      BK_MARK: begin
        if (mark_last) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      free_map <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        BK_IDLE: begin
          if (q_valid) begin
            unique case (q_req.cls)
              CLS_FREE: begin
                if (free_ok) begin
                  free_map[free_idx] <= 1'b1;
                end
                done          <= 1'b1;
                status        <= ST_FREED;
                start_block   <= '0;
                blocks_needed <= '0;
              end
              CLS_ZERO: begin
                done          <= 1'b1;
                status        <= ST_ZERO;
                start_block   <= '0;
                blocks_needed <= '0;
              end
              CLS_ALLOC: begin
                fid <= q_req.file_id;
              end
              default: ;
            endcase
          end
        end
        BK_DIV: begin
          if (div_done) begin
            need     <= div_q + NEED_W'(1);
            scan_idx <= '0;
            run      <= '0;
          end
        end
        BK_SCAN: begin
          run <= run_inc;
          // A free block after a used one opens a new candidate run.
          if (cur_free && run == '0) begin
            run_start <= scan_idx;
          end
          if (hit) begin
            mark_k <= '0;
          end else if (scan_last) begin
            done          <= 1'b1;
            status        <= ST_NOROOM;
            start_block   <= '0;
            blocks_needed <= need;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        BK_MARK: begin
          free_map[mark_addr] <= 1'b0;
          if (mark_last) begin
            done          <= 1'b1;
            status        <= ST_ALLOC;
            start_block   <= start_wide[START_W-1:0];
            blocks_needed <= need;
          end else begin
            mark_k <= mark_k + IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_MARK) begin
      owner_mem[mark_addr] <= fid;
      part_mem[mark_addr]  <= part_wide[PART_W-1:0];
    end
  end

endmodule

// ----- rtl/contiguous_first_fit_allocator_top.sv -----
// A free or zero-size request is answered once the back end is idle; an allocation runs
// the serial divider, then scans up to NUM_BLOCKS free-map bits (one per cycle) for a run,
// then, if one is found, marks it (one block marked per cycle).
// Flow: one request at a time in the back end; a 2-entry queue in front takes new
// requests meanwhile, and busy is high only while that queue is full.
// Reset clears the free map (no block free), empties the queue and sets block_bytes to 1.
module contiguous_first_fit_allocator_top #(
  parameter int NUM_BLOCKS = cffa_pkg::NUM_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [cffa_pkg::KIND_W-1:0]   kind,
  input  logic [cffa_pkg::BIDX_W-1:0]   block_index,
  input  logic [cffa_pkg::FID_W-1:0]    file_id,
  input  logic [cffa_pkg::FBYTES_W-1:0] file_bytes,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cffa_pkg::BSIZE_W-1:0]  cfg_data,
  output logic                          done,
  output logic [cffa_pkg::STATUS_W-1:0] status,
  output logic [cffa_pkg::START_W-1:0]  start_block,
  output logic [cffa_pkg::NEED_W-1:0]   blocks_needed
);
  import cffa_pkg::*;

  logic [BSIZE_W-1:0] block_bytes;
  logic               q_valid;
  req_t               q_req;
  logic               pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= BSIZE_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      block_bytes <= cfg_data;
    end
  end

  cffa_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .block_index (block_index),
    .file_id     (file_id),
    .file_bytes  (file_bytes),
    .q_valid     (q_valid),
    .q_req       (q_req),
    .pop         (pop)
  );

  cffa_back #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_req         (q_req),
    .pop           (pop),
    .block_bytes   (block_bytes),
    .done          (done),
    .status        (status),
    .start_block   (start_block),
    .blocks_needed (blocks_needed)
  );

  // The back end only takes a request that the queue actually holds.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("request taken from an empty queue");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_freed_fields: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_FREED || status == ST_ZERO) |->
      start_block == '0 && blocks_needed == '0)
    else $error("free or rejected request reports a block or count");

  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_ALLOC || status == ST_NOROOM) |-> blocks_needed != '0)
    else $error("allocation reports a zero block count");

endmodule

// ----- dv/tb_contiguous_first_fit_allocator_top.sv -----
// Self-checking testbench for the contiguous first-fit block allocator top level.
module tb_contiguous_first_fit_allocator_top;
  import cffa_pkg::*;

  localparam int   NB          = NUM_BLOCKS_DEF;
  localparam int   STALL_LIMIT = 2000;
  localparam int   TAIL_CYCLES = 120;
  localparam int   PHASE_ITEMS = 140;
  localparam int   MAX_SHOWN   = 10;
  localparam logic KIND_FREE   = 1'b0;
  localparam logic KIND_ALLOC  = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [BIDX_W-1:0]   block_index;
    logic [FID_W-1:0]    file_id;
    logic [FBYTES_W-1:0] file_bytes;
    logic [2:0]          gap;
  } file_request_t;

  typedef struct packed {
    status_t             status;
    logic [START_W-1:0]  start_block;
    logic [NEED_W-1:0]   blocks_needed;
  } alloc_result_t;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                start         = 1'b0;
  logic                busy;
  logic [KIND_W-1:0]   kind          = '0;
  logic [BIDX_W-1:0]   block_index   = '0;
  logic [FID_W-1:0]    file_id       = '0;
  logic [FBYTES_W-1:0] file_bytes    = '0;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [BSIZE_W-1:0]  cfg_data      = '0;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [START_W-1:0]  start_block;
  logic [NEED_W-1:0]   blocks_needed;

  // Predictor state.
  logic [BSIZE_W-1:0]  bytes_per_block = 13'd1;
  logic [NB-1:0]       free_blocks     = '0;
  logic [FID_W-1:0]    owners [NB];
  logic [PART_W-1:0]   parts  [NB];

  file_request_t pending_requests[$];
  alloc_result_t awaited_results[$];
  file_request_t staged;
  file_request_t on_pins;
  bit            holding   = 1'b0;
  int            wait_left = 0;
  bit            took      = 1'b0;
  bit            quiet     = 1'b0;
  int            failures  = 0;
  int            stall_cycles = 0;

  logic [BSIZE_W-1:0] size_plan [8] = '{13'd4096, 13'd1, 13'd8191, 13'd0,
                                        13'd512, 13'd37, 13'd2048, 13'd1};

  contiguous_first_fit_allocator_top DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .block_index   (block_index),
    .file_id       (file_id),
    .file_bytes    (file_bytes),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .done          (done),
    .status        (status),
    .start_block   (start_block),
    .blocks_needed (blocks_needed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // First fit: the lowest run of free blocks long enough for the file wins.
  function automatic alloc_result_t predict_outcome(file_request_t r);
    alloc_result_t res;
    int unsigned   divisor;
    int unsigned   need;
    int unsigned   run;
    int unsigned   first;
    int unsigned   j;
    bit            found;
    res.status        = ST_FREED;
    res.start_block   = '0;
    res.blocks_needed = '0;
    if (r.kind == KIND_FREE) begin
      if (r.block_index < NB) free_blocks[r.block_index] = 1'b1;
      return res;
    end
    if (r.file_bytes == 0) begin
      res.status = ST_ZERO;
      return res;
    end
    divisor = (bytes_per_block == 0) ? 1 : bytes_per_block;
    need    = (r.file_bytes + divisor - 1) / divisor;
    run     = 0;
    first   = 0;
    found   = 1'b0;
    for (j = 0; j < NB && !found; j++) begin
      if (free_blocks[j]) begin
        if (run == 0) first = j;
        run++;
      end else begin
        run = 0;
      end
      if (run == need) found = 1'b1;
    end
    res.blocks_needed = need[NEED_W-1:0];
    if (!found) begin
      res.status = ST_NOROOM;
      return res;
    end
    for (j = 0; j < need; j++) begin
      free_blocks[first + j] = 1'b0;
      owners[first + j]      = r.file_id;
      parts[first + j]       = PART_W'(j + 1);
    end
    res.status      = ST_ALLOC;
    res.start_block = first[START_W-1:0];
    return res;
  endfunction

  function automatic logic [FBYTES_W-1:0] bytes_for(int unsigned n, int unsigned divisor);
    int unsigned most;
    int unsigned base;
    most = (65535 + divisor - 1) / divisor;
    if (n > most) n = most;
    base = (n - 1) * divisor;
    return FBYTES_W'(base +
      $urandom_range(1, (65535 - base < divisor) ? 65535 - base : divisor));
  endfunction

  task automatic add_request(input logic k, input logic [BIDX_W-1:0] idx,
                             input logic [FID_W-1:0] fid, input logic [FBYTES_W-1:0] nbytes);
    file_request_t r;
    r.kind        = k;
    r.block_index = idx;
    r.file_id     = fid;
    r.file_bytes  = nbytes;
    r.gap         = quiet ? 3'd0 : 3'($urandom_range(0, 5));
    pending_requests.push_back(r);
  endtask

  // Mostly freed runs followed by files sized to fit; the rest is noise.
  task automatic random_chunk(input int unsigned divisor);
    int unsigned pick;
    int unsigned first;
    int unsigned len;
    int unsigned i;
    quiet = ($urandom_range(0, 3) == 0);
    pick  = $urandom_range(0, 99);
    if (pick < 35) begin
      first = $urandom_range(0, NB - 1);
      len   = $urandom_range(1, 8);
      for (i = first; i < first + len && i < NB; i++)
        add_request(KIND_FREE, BIDX_W'(i), FID_W'($urandom_range(0, 255)),
                    FBYTES_W'($urandom_range(0, 65535)));
    end else if (pick < 75) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, NB + 2) : $urandom_range(1, 6);
      add_request(KIND_ALLOC, BIDX_W'($urandom_range(0, 31)), FID_W'($urandom_range(0, 255)),
                  bytes_for(len, divisor));
    end else if (pick < 82) begin
      add_request(KIND_ALLOC, BIDX_W'($urandom_range(0, 31)), FID_W'($urandom_range(0, 255)),
                  16'd0);
    end else if (pick < 90) begin
      add_request(KIND_ALLOC, BIDX_W'($urandom_range(0, 31)), FID_W'($urandom_range(0, 255)),
                  FBYTES_W'($urandom_range(0, 65535)));
    end else begin
      add_request(KIND_FREE, BIDX_W'($urandom_range(0, 31)), FID_W'($urandom_range(0, 255)),
                  FBYTES_W'($urandom_range(0, 65535)));
    end
  endtask

  task automatic directed_requests();
    quiet = 1'b0;
    add_request(KIND_ALLOC, 5'd0,  8'h00, 16'd1);
    add_request(KIND_ALLOC, 5'd31, 8'hFF, 16'd0);
    add_request(KIND_ALLOC, 5'd0,  8'hA5, 16'hFFFF);
    add_request(KIND_FREE,  5'd0,  8'h00, 16'd0);
    add_request(KIND_FREE,  5'd31, 8'hFF, 16'hFFFF);
    // Freeing a block that is already free leaves the map alone.
    add_request(KIND_FREE,  5'd31, 8'h00, 16'd0);
    add_request(KIND_ALLOC, 5'd0,  8'h01, 16'd2);
    add_request(KIND_ALLOC, 5'd0,  8'h00, 16'd1);
    add_request(KIND_ALLOC, 5'd0,  8'hFF, 16'd1);
    add_request(KIND_ALLOC, 5'd0,  8'h02, 16'd1);
    for (int i = 1; i <= 4; i++) add_request(KIND_FREE, BIDX_W'(i), 8'h00, 16'd0);
    add_request(KIND_ALLOC, 5'd0,  8'h03, 16'd5);
    add_request(KIND_ALLOC, 5'd0,  8'h5A, 16'd4);
    for (int i = 7; i <= 9; i++) add_request(KIND_FREE, BIDX_W'(i), 8'h00, 16'd0);
    add_request(KIND_ALLOC, 5'd0,  8'h77, 16'd2);
    add_request(KIND_ALLOC, 5'd0,  8'h88, 16'd1);
  endtask

  // Returns once every request is taken and every result has come back.
  task automatic drain();
    while (pending_requests.size() != 0 || holding || start || awaited_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_block_bytes(input logic [BSIZE_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic note_mismatch(input string what);
    failures++;
    if (failures <= MAX_SHOWN) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin : sample
    alloc_result_t want;
    if (!rst) begin
      if (done) begin
        if (awaited_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result status %0d start %0d count %0d",
                                  status, start_block, blocks_needed));
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.status || start_block !== want.start_block ||
              blocks_needed !== want.blocks_needed)
            note_mismatch($sformatf(
              "expected status %0d start %0d count %0d, got status %0d start %0d count %0d",
              want.status, want.start_block, want.blocks_needed,
              status, start_block, blocks_needed));
        end
      end
      if (start && !busy) begin
        awaited_results.push_back(predict_outcome(on_pins));
        took = 1'b1;
      end
      if (cfg_valid && cfg_ready) bytes_per_block = cfg_data;
    end
  end

  always @(negedge clk) begin : drive
    logic raise;
    raise = start && !took;
    took  = 1'b0;
    if (!rst && !raise) begin
      if (!holding && pending_requests.size() != 0) begin
        staged    = pending_requests.pop_front();
        holding   = 1'b1;
        wait_left = staged.gap;
      end
      if (holding) begin
        if (wait_left == 0) begin
          raise       = 1'b1;
          holding     = 1'b0;
          on_pins     = staged;
          kind        <= staged.kind;
          block_index <= staged.block_index;
          file_id     <= staged.file_id;
          file_bytes  <= staged.file_bytes;
        end else begin
          wait_left--;
        end
      end
    end
    start <= raise;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles = 0;
    else stall_cycles = stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("contiguous_first_fit_allocator_top regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int p;
    int target;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // The directed part runs on the reset block size of one byte.
    directed_requests();
    drain();
    for (p = 0; p < 8; p++) begin
      write_block_bytes(size_plan[p]);
      target = pending_requests.size() + PHASE_ITEMS;
      while (pending_requests.size() < target)
        random_chunk((size_plan[p] == 0) ? 1 : size_plan[p]);
      drain();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    failures += awaited_results.size();
    if (failures == 0)
      $display("contiguous_first_fit_allocator_top regression: pass");
    else
      $display("contiguous_first_fit_allocator_top regression: fail");
    $finish;
  end

endmodule
